@@ hw/rtl/rle_byte_decompressor_wordpack_assert.svh @@
// assertion macros shared by the decompressor rtl
`ifndef RLE_BYTE_DECOMPRESSOR_WORDPACK_ASSERT_SVH
`define RLE_BYTE_DECOMPRESSOR_WORDPACK_ASSERT_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define RBD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rbd assertion failed");
// condition that must never hold outside reset
`define RBD_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("rbd forbidden condition");
`else
`define RBD_ASSERT(lbl, prop)
`define RBD_NEVER(lbl, cond)
`endif
`endif

@@ hw/rtl/rbd_pkg.sv @@
// types and constants of the rle decompressor
`timescale 1ns / 1ps
package rbd_pkg;

   localparam logic [1:0] REG_TOTAL_SIZE  = 2'd0;
   localparam logic [1:0] REG_DEST_OFFSET = 2'd1;

   localparam logic [7:0] RUN_BIAS = 8'd3;
   localparam logic [7:0] LIT_BIAS = 8'd1;

   localparam int CMD_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_RUN    = 3'b010,
      PH_LIT    = 3'b100
   } phase_type;

   // one byte repeated count times
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] count;
      logic       is_last;
      logic       first;
      logic [1:0] offset;
   } cmd_type;

endpackage

@@ hw/rtl/rbd_front.sv @@
// front end: takes compressed bytes, parses headers, issues byte commands
`timescale 1ns / 1ps
`include "rle_byte_decompressor_wordpack_assert.svh"
module rbd_front #(
   parameter int SIZE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_in_byte,
   output logic                 req_full,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SIZE_BITS-1:0] csr_wdata,
   output logic                 cmd_push,
   output rbd_pkg::cmd_type     cmd,
   input  logic                 cmd_full
);
   import rbd_pkg::*;

   logic [SIZE_BITS-1:0] total_size_ff, total_size_in;
   logic [1:0]           dest_offset_ff, dest_offset_in;
   phase_type            phase_ff, phase_in;
   logic                 armed_ff, armed_in;
   logic                 first_ff, first_in;
   logic [1:0]           offset_ff, offset_in;
   logic [7:0]           block_left_ff, block_left_in;
   logic [SIZE_BITS:0]   bytes_left_ff, bytes_left_in;

   logic               accept;
   logic               done;
   logic [7:0]         len;
   logic [7:0]         blk_dec;
   logic [SIZE_BITS:0] base;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign done     = bytes_left_ff[SIZE_BITS] || (bytes_left_ff == '0);
   assign len      = {1'b0, req_in_byte[6:0]} + (req_in_byte[7] ? RUN_BIAS : LIT_BIAS);
   assign blk_dec  = block_left_ff - 8'd1;
   assign base     = armed_ff ? {1'b0, total_size_ff} : bytes_left_ff;

   always_comb begin
      total_size_in  = total_size_ff;
      dest_offset_in = dest_offset_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TOTAL_SIZE:  total_size_in  = csr_wdata;
            REG_DEST_OFFSET: dest_offset_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      armed_in      = armed_ff;
      first_in      = first_ff;
      offset_in     = offset_ff;
      block_left_in = block_left_ff;
      bytes_left_in = bytes_left_ff;
      cmd_push      = 1'b0;
      cmd.data      = req_in_byte;
      cmd.count     = 8'd1;
      cmd.is_last   = 1'b0;
      cmd.first     = first_ff;
      cmd.offset    = offset_ff;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (armed_ff) begin
                  first_in  = 1'b1;
                  offset_in = dest_offset_ff;
                  armed_in  = 1'b0;
               end
               block_left_in = len;
               bytes_left_in = base - {{(SIZE_BITS-7){1'b0}}, len};
               phase_in      = req_in_byte[7] ? PH_RUN : PH_LIT;
            end
            PH_RUN: begin
               cmd_push    = 1'b1;
               cmd.count   = block_left_ff;
               cmd.is_last = done;
               first_in    = 1'b0;
               phase_in    = PH_HEADER;
               armed_in    = done;
            end
            PH_LIT: begin
               cmd_push      = 1'b1;
               cmd.is_last   = (blk_dec == 8'd0) && done;
               first_in      = 1'b0;
               block_left_in = blk_dec;
               if (blk_dec == 8'd0) begin
                  phase_in = PH_HEADER;
                  armed_in = done;
               end
            end
            default: phase_in = PH_HEADER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff  <= {{(SIZE_BITS-1){1'b0}}, 1'b1};
         dest_offset_ff <= 2'd0;
         phase_ff       <= PH_HEADER;
         armed_ff       <= 1'b1;
         first_ff       <= 1'b0;
      end else begin
         total_size_ff  <= total_size_in;
         dest_offset_ff <= dest_offset_in;
         phase_ff       <= phase_in;
         armed_ff       <= armed_in;
         first_ff       <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff     <= offset_in;
      block_left_ff <= block_left_in;
      bytes_left_ff <= bytes_left_in;
   end

   `RBD_ASSERT(a_armed_hdr, armed_ff |-> phase_ff == PH_HEADER)
   `RBD_ASSERT(a_cmd_count, cmd_push |-> cmd.count != 8'd0)

endmodule

@@ hw/rtl/rbd_cmd_fifo.sv @@
// short command queue between the parser and the packer
`timescale 1ns / 1ps
`include "rle_byte_decompressor_wordpack_assert.svh"
module rbd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbd_pkg::cmd_type wr_cmd,
   output logic             full,
   input  logic             pop,
   output rbd_pkg::cmd_type rd_cmd,
   output logic             valid
);
   import rbd_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(CMD_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rd_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   `RBD_NEVER(a_no_overflow, push && full)

endmodule

@@ hw/rtl/rbd_pack.sv @@
// back end: expands byte commands and packs bytes into lane-masked words
`timescale 1ns / 1ps
`include "rle_byte_decompressor_wordpack_assert.svh"
module rbd_pack (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rbd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_out_word,
   output logic [3:0]       rsp_byte_lanes,
   output logic             rsp_last_word
);
   import rbd_pkg::*;

   logic        active_ff, active_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  remain_ff, remain_in;
   logic        is_last_ff, is_last_in;
   logic [1:0]  lane_pos_ff, lane_pos_in;
   logic [31:0] word_ff, word_in;
   logic [3:0]  mask_ff, mask_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic [3:0]  out_lanes_ff, out_lanes_in;
   logic        out_last_ff, out_last_in;

   logic [2:0]  room;
   logic [2:0]  take;
   logic [2:0]  end_pos;
   logic        blk_end;
   logic        emit;
   logic        out_free;
   logic        step;
   logic        xfer_out;
   logic [3:0]  new_lanes;
   logic [31:0] word_next;

   assign room     = 3'd4 - {1'b0, lane_pos_ff};
   assign take     = (remain_ff < {5'd0, room}) ? remain_ff[2:0] : room;
   assign end_pos  = {1'b0, lane_pos_ff} + take;
   assign blk_end  = ({5'd0, take} == remain_ff);
   assign emit     = (end_pos == 3'd4) || (is_last_ff && blk_end);
   assign xfer_out = rsp_pop && rsp_valid_ff;
   assign out_free = !rsp_valid_ff || xfer_out;
   assign step     = active_ff && (!emit || out_free);
   assign cmd_pop  = cmd_valid && (!active_ff || (step && blk_end));

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_out_word   = out_word_ff;
   assign rsp_byte_lanes = out_lanes_ff;
   assign rsp_last_word  = out_last_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         new_lanes[i] = (3'(i) >= {1'b0, lane_pos_ff}) && (3'(i) < end_pos);
         word_next[8*i +: 8] = new_lanes[i] ? data_ff : word_ff[8*i +: 8];
      end
   end

   always_comb begin
      active_in    = active_ff;
      data_in      = data_ff;
      remain_in    = remain_ff;
      is_last_in   = is_last_ff;
      lane_pos_in  = lane_pos_ff;
      word_in      = word_ff;
      mask_in      = mask_ff;
      rsp_valid_in = xfer_out ? 1'b0 : rsp_valid_ff;
      out_word_in  = out_word_ff;
      out_lanes_in = out_lanes_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         remain_in = remain_ff - {5'd0, take};
         if (blk_end) begin
            active_in = 1'b0;
         end
         if (emit) begin
            rsp_valid_in = 1'b1;
            out_word_in  = word_next;
            out_lanes_in = mask_ff | new_lanes;
            out_last_in  = is_last_ff && blk_end;
            word_in      = '0;
            mask_in      = '0;
            lane_pos_in  = 2'd0;
         end else begin
            word_in     = word_next;
            mask_in     = mask_ff | new_lanes;
            lane_pos_in = end_pos[1:0];
         end
      end
      if (cmd_pop) begin
         active_in  = 1'b1;
         data_in    = cmd.data;
         remain_in  = cmd.count;
         is_last_in = cmd.is_last;
         if (cmd.first) begin
            lane_pos_in = cmd.offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lane_pos_ff  <= 2'd0;
         word_ff      <= '0;
         mask_ff      <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         lane_pos_ff  <= lane_pos_in;
         word_ff      <= word_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      remain_ff    <= remain_in;
      is_last_ff   <= is_last_in;
      out_word_ff  <= out_word_in;
      out_lanes_ff <= out_lanes_in;
      out_last_ff  <= out_last_in;
   end

   `RBD_ASSERT(a_emit_valid, step && emit |=> rsp_valid_ff)
   `RBD_ASSERT(a_active_nz, active_ff |-> remain_ff != 8'd0)
   `RBD_ASSERT(a_lanes_nz, rsp_valid_ff |-> out_lanes_ff != 4'd0)

endmodule

@@ hw/rtl/rle_byte_decompressor_wordpack.sv @@
// top level of the rle byte decompressor with 32-bit word packing
// usage:
//   compressed bytes enter through req_push / req_full / req_in_byte, one per
//   transfer. a header with bit 7 set starts a run of (low bits + 3) copies of
//   the next byte; otherwise (low bits + 1) literal bytes follow.
//   packed words leave through rsp_empty / rsp_pop with the lane mask and a
//   last flag on the final word of a stream; the next stream follows at once.
//   csr_we / csr_index / csr_wdata set total_size (0) and dest_offset (1);
//   they are sampled when the first header of a stream is taken.
// throughput: one input byte per cycle while the command queue has room; the
//   packer places up to four bytes of a run per cycle while the rsp side takes
//   its words, so runs fill the two-entry queue and stall input.
// path: a data byte goes from the command queue entry through the packer's
//   command registers to the output word register on the rsp side.
// stall: a held rsp side keeps the word in place, the packer then waits and
//   the queue fills, after which req_full rises.
// reset: synchronous; total_size = 1, dest_offset = 0, queue and packer empty.
`timescale 1ns / 1ps
module rle_byte_decompressor_wordpack #(
   parameter int SIZE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_in_byte,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [31:0]          rsp_out_word,
   output logic [3:0]           rsp_byte_lanes,
   output logic                 rsp_last_word,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SIZE_BITS-1:0] csr_wdata
);
   import rbd_pkg::*;

   cmd_type wr_cmd;
   cmd_type rd_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_valid;

   rbd_front #(
      .SIZE_BITS(SIZE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_in_byte(req_in_byte),
      .req_full   (req_full),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_push   (cmd_push),
      .cmd        (wr_cmd),
      .cmd_full   (cmd_full)
   );

   rbd_cmd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wr_cmd(wr_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rd_cmd(rd_cmd),
      .valid (cmd_valid)
   );

   rbd_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (rd_cmd),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_word  (rsp_out_word),
      .rsp_byte_lanes(rsp_byte_lanes),
      .rsp_last_word (rsp_last_word)
   );

endmodule

@@ tb/sv/rle_byte_decompressor_wordpack_checker.sv @@
// checker for the rle decompressor: predicts packed words from observed transfers and compares them
`timescale 1ns / 1ps
module rle_byte_decompressor_wordpack_checker #(
   parameter int SIZE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_full,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic [31:0]          rsp_out_word,
   input  logic [3:0]           rsp_byte_lanes,
   input  logic                 rsp_last_word,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SIZE_BITS-1:0] csr_wdata,
   output int                   fail_count,
   output int                   outstanding,
   output int                   words_seen,
   output int                   streams_done
);
   import rbd_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [3:0]  lanes;
      logic        last;
   } packed_word_type;

   packed_word_type pending_words[$];

   logic [SIZE_BITS-1:0] cfg_total;
   logic [1:0]           cfg_offset;

   phase_type   cur_phase;
   int          block_left;
   longint      bytes_left;
   logic [31:0] word_buf;
   logic [3:0]  lane_mask;
   logic [1:0]  lane_pos;
   bit          armed;

   task automatic restart_stream();
      cur_phase  = PH_HEADER;
      block_left = 0;
      bytes_left = longint'(cfg_total);
      word_buf   = '0;
      lane_mask  = '0;
      lane_pos   = cfg_offset;
      armed      = 1'b1;
   endtask

   task automatic place_byte(input logic [7:0] b, input bit final_byte);
      packed_word_type w;
      word_buf = word_buf | (32'(b) << (8 * lane_pos));
      lane_mask[lane_pos] = 1'b1;
      if (lane_pos == 2'd3 || final_byte) begin
         w.word  = word_buf;
         w.lanes = lane_mask;
         w.last  = final_byte;
         pending_words.push_back(w);
         word_buf  = '0;
         lane_mask = '0;
         lane_pos  = 2'd0;
      end else begin
         lane_pos++;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      if (cur_phase == PH_HEADER) begin
         if (armed) begin
            bytes_left = longint'(cfg_total);
            lane_pos   = cfg_offset;
            word_buf   = '0;
            lane_mask  = '0;
            armed      = 1'b0;
         end
         if (b[7]) begin
            block_left = int'(b[6:0]) + int'(RUN_BIAS);
            cur_phase  = PH_RUN;
         end else begin
            block_left = int'(b[6:0]) + int'(LIT_BIAS);
            cur_phase  = PH_LIT;
         end
         bytes_left -= block_left;
      end else begin
         if (cur_phase == PH_RUN) begin
            while (block_left > 0) begin
               block_left--;
               place_byte(b, block_left == 0 && bytes_left <= 0);
            end
         end else begin
            if (block_left > 0) block_left--;
            place_byte(b, block_left == 0 && bytes_left <= 0);
         end
         if (block_left == 0) begin
            if (bytes_left <= 0) restart_stream();
            else cur_phase = PH_HEADER;
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch
      packed_word_type want;
      if (reset) begin
         cfg_total  = SIZE_BITS'(1);
         cfg_offset = 2'd0;
         restart_stream();
         pending_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            words_seen++;
            if (rsp_last_word) streams_done++;
            if (pending_words.size() == 0) begin
               note_mismatch($sformatf("unexpected word %h lanes %b last %b",
                  rsp_out_word, rsp_byte_lanes, rsp_last_word));
            end else begin
               want = pending_words.pop_front();
               if (rsp_out_word !== want.word || rsp_byte_lanes !== want.lanes ||
                   rsp_last_word !== want.last)
                  note_mismatch($sformatf(
                     "expected word %h lanes %b last %b, got word %h lanes %b last %b",
                     want.word, want.lanes, want.last,
                     rsp_out_word, rsp_byte_lanes, rsp_last_word));
            end
         end
         if (csr_we) begin
            if (csr_index == REG_TOTAL_SIZE) cfg_total = csr_wdata;
            else if (csr_index == REG_DEST_OFFSET) cfg_offset = csr_wdata[1:0];
         end
         if (req_push && !req_full) decode_byte(req_in_byte);
      end
      outstanding = pending_words.size();
   end

endmodule

@@ tb/sv/rle_byte_decompressor_wordpack_tb.sv @@
// testbench top for the rle decompressor: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module rle_byte_decompressor_wordpack_tb;
   import rbd_pkg::*;

   localparam int SIZE_BITS     = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 360;

   localparam logic [1:0] REG_UNUSED_A = 2'd2;
   localparam logic [1:0] REG_UNUSED_B = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic [7:0]           req_in_byte = '0;
   logic                 rsp_pop = 1'b0;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_out_word;
   logic [3:0]  rsp_byte_lanes;
   logic        rsp_last_word;

   int fail_count;
   int outstanding;
   int words_seen;
   int streams_done;

   int cycles;
   int bytes_sent;
   int phase_count;
   int target;
   int goal;
   int cur_total = 1;
   int stream_left;
   bit stream_open;
   bit mid_done;
   bit calm;

   rle_byte_decompressor_wordpack #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_in_byte(req_in_byte), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_out_word(rsp_out_word),
      .rsp_byte_lanes(rsp_byte_lanes), .rsp_last_word(rsp_last_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rle_byte_decompressor_wordpack_checker #(.SIZE_BITS(SIZE_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_in_byte(req_in_byte), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_out_word(rsp_out_word),
      .rsp_byte_lanes(rsp_byte_lanes), .rsp_last_word(rsp_last_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding),
      .words_seen(words_seen), .streams_done(streams_done)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("rle_byte_decompressor_wordpack_tb: FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] random_header();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 8'($urandom_range(0, 7));
      else if (pick < 70) return 8'h80 | 8'($urandom_range(0, 9));
      else if (pick < 82) return 8'h80 | 8'($urandom_range(0, 127));
      else if (pick < 90) return 8'($urandom_range(8, 31));
      else if (pick < 96) return 8'($urandom);
      else return pick[0] ? 8'hFF : 8'h7F;
   endfunction

   function automatic int random_total();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 0;
      else if (pick < 15) return 1;
      else if (pick < 45) return $urandom_range(2, 16);
      else if (pick < 90) return $urandom_range(17, 200);
      else return $urandom_range(201, 600);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // header plus its payload, keeping track of where the stream ends
   task automatic send_block(input logic [7:0] header);
      int len;
      int i;
      len = header[7] ? int'(header[6:0]) + int'(RUN_BIAS) : int'(header[6:0]) + int'(LIT_BIAS);
      if (!stream_open) begin
         stream_left = cur_total;
         stream_open = 1'b1;
      end
      stream_left -= len;
      send_byte(header);
      if (header[7]) begin
         send_byte(8'($urandom));
      end else begin
         for (i = 0; i < len; i++) send_byte(8'($urandom));
      end
      if (stream_left <= 0) stream_open = 1'b0;
   endtask

   task automatic drain_outputs();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [SIZE_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_TOTAL_SIZE) cur_total = int'(val);
   endtask

   // result side pops with random stalls
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: one literal byte ends the stream
      send_byte(8'h00);
      send_byte(8'hFF);
      drain_outputs();

      // zero size with the longest run starting at the top lane
      write_reg(REG_TOTAL_SIZE, '0);
      write_reg(REG_DEST_OFFSET, SIZE_BITS'(3));
      send_byte(8'hFF);
      send_byte(8'hA5);
      drain_outputs();

      // overshooting run, unknown indexes must not disturb the config
      write_reg(REG_TOTAL_SIZE, SIZE_BITS'(5));
      write_reg(REG_DEST_OFFSET, SIZE_BITS'(1));
      write_reg(REG_UNUSED_A, '1);
      write_reg(REG_UNUSED_B, SIZE_BITS'(2));
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h5A);
      drain_outputs();

      // config written mid-stream applies to the next one; full final word
      write_reg(REG_TOTAL_SIZE, SIZE_BITS'(8));
      write_reg(REG_DEST_OFFSET, '0);
      send_byte(8'h03);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      drain_outputs();
      write_reg(REG_TOTAL_SIZE, SIZE_BITS'(1));
      write_reg(REG_DEST_OFFSET, SIZE_BITS'(2));
      send_byte(8'h03);
      send_byte(8'hAA);
      send_byte(8'h55);
      send_byte(8'hF0);
      send_byte(8'h0F);
      drain_outputs();
      send_byte(8'h00);
      send_byte(8'h3C);
      drain_outputs();

      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         drain_outputs();
         calm = ($urandom_range(0, 3) == 0);
         write_reg(REG_TOTAL_SIZE, SIZE_BITS'(random_total()));
         write_reg(REG_DEST_OFFSET, SIZE_BITS'($urandom_range(0, 3)));
         phase_count++;
         goal = bytes_sent + 30;
         mid_done = 1'b0;
         while (bytes_sent < goal) begin
            send_block(random_header());
            if (!mid_done && stream_open && bytes_sent > goal - 15 &&
                $urandom_range(0, 3) == 0) begin
               drain_outputs();
               write_reg(REG_TOTAL_SIZE, SIZE_BITS'(random_total()));
               write_reg(REG_DEST_OFFSET, SIZE_BITS'($urandom_range(0, 3)));
               mid_done = 1'b1;
            end
         end
         while (stream_open) send_block(random_header());
      end

      // largest size: the stream stays open, words come out only when their top lane is filled
      drain_outputs();
      calm = 1'b0;
      write_reg(REG_TOTAL_SIZE, '1);
      write_reg(REG_DEST_OFFSET, SIZE_BITS'(3));
      repeat (6) send_block(random_header());
      drain_outputs();

      $display("covered %0d compressed bytes over %0d random config phases",
         bytes_sent, phase_count);
      $display("checked %0d packed words in %0d finished streams", words_seen, streams_done);
      if (fail_count == 0 && outstanding == 0) begin
         $display("rle_byte_decompressor_wordpack_tb: PASS");
      end else begin
         $display("rle_byte_decompressor_wordpack_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_front.sv
hw/rtl/rbd_cmd_fifo.sv
hw/rtl/rbd_pack.sv
hw/rtl/rle_byte_decompressor_wordpack.sv
tb/sv/rle_byte_decompressor_wordpack_checker.sv
tb/sv/rle_byte_decompressor_wordpack_tb.sv
